@@ src/assert_macros.svh @@
// Assertion macros shared by the lux calculator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define LALC_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define LALC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define LALC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/lalc_pkg.sv @@
// Package for the ambient light lux calculator: widths, coefficients,
// band codes, microcode types and the microcode program. No dependencies.
`default_nettype none

package lalc_pkg;

    localparam int COEF_FRAC_BITS = 14;

    localparam int CH_W      = 16;
    localparam int LUX_W     = 20;
    localparam int BAND_W    = 3;
    localparam int GAIN_W    = 7;
    localparam int INTEG_W   = 4;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    localparam int COEF_W = COEF_FRAC_BITS + 3;
    localparam int PROD_W = COEF_W + CH_W;
    localparam int ACC_W  = COEF_FRAC_BITS + 20;
    localparam int NUM_W  = 21;
    localparam int DEN_W  = GAIN_W + INTEG_W;
    localparam int ITER_W = $clog2(NUM_W);
    localparam int CMP_W  = 24;

    localparam logic [LUX_W-1:0] LUX_MAX = LUX_W'(600000);

    // round half up of c_e4 * 1e-4 * 2^COEF_FRAC_BITS
    function automatic logic [COEF_W-1:0] q_coef(input longint unsigned c_e4);
        longint unsigned v;
        v = ((c_e4 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;
        return COEF_W'(v);
    endfunction

    localparam logic [COEF_W-1:0] C_A1 = q_coef(64'd17743);
    localparam logic [COEF_W-1:0] C_B1 = q_coef(64'd11059);
    localparam logic [COEF_W-1:0] C_A2 = q_coef(64'd42785);
    localparam logic [COEF_W-1:0] C_B2 = q_coef(64'd19548);
    localparam logic [COEF_W-1:0] C_A3 = q_coef(64'd5926);
    localparam logic [COEF_W-1:0] C_B3 = q_coef(64'd1185);

    localparam logic [CMP_W-1:0] RATIO_DEN = CMP_W'(100);
    localparam logic [CMP_W-1:0] RATIO_1   = CMP_W'(45);
    localparam logic [CMP_W-1:0] RATIO_2   = CMP_W'(64);
    localparam logic [CMP_W-1:0] RATIO_3   = CMP_W'(85);

    typedef logic [BAND_W-1:0] t_band;
    localparam t_band BAND_ZERO = 3'd0;
    localparam t_band BAND_1    = 3'd1;
    localparam t_band BAND_2    = 3'd2;
    localparam t_band BAND_3    = 3'd3;
    localparam t_band BAND_HIGH = 3'd4;
    localparam t_band BAND_HELD = 3'd5;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_GAIN  = 1'd0;
    localparam t_cfg_idx CFG_INTEG = 1'd1;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_CLASS,
        OP_NOP,
        OP_MUL_A,
        OP_MUL_B,
        OP_SUM,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NO_IN,
        COND_SPECIAL,
        COND_DIV_MORE,
        COND_OUT_FREE
    } t_cond;

    typedef logic [3:0] t_step;
    localparam t_step STEP_LOAD     = 4'd0;
    localparam t_step STEP_CLASS    = 4'd1;
    localparam t_step STEP_BRANCH   = 4'd2;
    localparam t_step STEP_MUL_A    = 4'd3;
    localparam t_step STEP_MUL_B    = 4'd4;
    localparam t_step STEP_SUM      = 4'd5;
    localparam t_step STEP_DIV_INIT = 4'd6;
    localparam t_step STEP_DIV      = 4'd7;
    localparam t_step STEP_DIV_END  = 4'd8;
    localparam t_step STEP_EMIT     = 4'd9;
    localparam t_step STEP_RETRY    = 4'd10;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic special;
        logic div_more;
        logic out_free;
    } t_stat;

    // microcode ROM: jump to target when cond holds, else step + 1
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        case (s)
            STEP_LOAD:     w = '{OP_LOAD,     COND_NO_IN,    STEP_LOAD};
            STEP_CLASS:    w = '{OP_CLASS,    COND_NEXT,     STEP_LOAD};
            STEP_BRANCH:   w = '{OP_NOP,      COND_SPECIAL,  STEP_EMIT};
            STEP_MUL_A:    w = '{OP_MUL_A,    COND_NEXT,     STEP_LOAD};
            STEP_MUL_B:    w = '{OP_MUL_B,    COND_NEXT,     STEP_LOAD};
            STEP_SUM:      w = '{OP_SUM,      COND_NEXT,     STEP_LOAD};
            STEP_DIV_INIT: w = '{OP_DIV_INIT, COND_NEXT,     STEP_LOAD};
            STEP_DIV:      w = '{OP_DIV_STEP, COND_DIV_MORE, STEP_DIV};
            STEP_DIV_END:  w = '{OP_DIV_END,  COND_NEXT,     STEP_LOAD};
            STEP_EMIT:     w = '{OP_EMIT,     COND_OUT_FREE, STEP_LOAD};
            STEP_RETRY:    w = '{OP_NOP,      COND_ALWAYS,   STEP_EMIT};
            default:       w = '{OP_NOP,      COND_ALWAYS,   STEP_LOAD};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ src/lalc_useq.sv @@
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on lalc_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module lalc_useq
    import lalc_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  t_stat i_stat,
    output t_op   o_op
);

    t_step  r_step;
    t_step  n_step;
    t_uword w_uw;
    logic   w_take;

    always_comb begin
        w_uw = ucode(r_step);
        case (w_uw.cond)
            COND_NEXT:     w_take = 1'b0;
            COND_ALWAYS:   w_take = 1'b1;
            COND_NO_IN:    w_take = !i_in_valid;
            COND_SPECIAL:  w_take = i_stat.special;
            COND_DIV_MORE: w_take = i_stat.div_more;
            COND_OUT_FREE: w_take = i_stat.out_free;
            default:       w_take = 1'b1;
        endcase
        n_step = w_take ? w_uw.target : r_step + t_step'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_LOAD;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_op = w_uw.op;

    `LALC_ASSERT_NEXT(a_accept_class, i_clk, i_rst_n, (o_op == OP_LOAD) && i_in_valid, r_step == STEP_CLASS, "accepted word did not start classification")
    `LALC_ASSERT_IMPLIES(a_div_in_loop, i_clk, i_rst_n, r_step == STEP_DIV, o_op == OP_DIV_STEP, "divider step outside division loop")

endmodule

`default_nettype wire

@@ src/lalc_dpath.sv @@
// Datapath: input capture, ratio classification, coefficient multiply,
// restoring divider, held lux and output register. Depends on lalc_pkg.
`default_nettype none

`include "assert_macros.svh"

module lalc_dpath
    import lalc_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  t_op                    i_op,
    input  wire                    i_in_valid,
    input  wire                    i_fresh,
    input  wire [CH_W-1:0]         i_ch_visible_ir,
    input  wire [CH_W-1:0]         i_ch_ir,
    input  wire                    i_cfg_we,
    input  wire [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [CFG_W-1:0]        i_cfg_data,
    input  wire                    i_out_ready,
    output t_stat                  o_stat,
    output logic                   o_out_valid,
    output logic [LUX_W-1:0]       o_lux_value,
    output t_band                  o_band
);

    logic              r_fresh,    n_fresh;
    logic [CH_W-1:0]   r_ch0,      n_ch0;
    logic [CH_W-1:0]   r_ch1,      n_ch1;
    t_band             r_band,     n_band;
    logic [LUX_W-1:0]  r_lux,      n_lux;
    logic [PROD_W-1:0] r_prod,     n_prod;
    logic [ACC_W-1:0]  r_acc,      n_acc;
    logic [NUM_W-1:0]  r_quo,      n_quo;
    logic [DEN_W-1:0]  r_rem,      n_rem;
    logic [DEN_W-1:0]  r_den,      n_den;
    logic [ITER_W-1:0] r_iter,     n_iter;
    logic [LUX_W-1:0]  r_out_lux,  n_out_lux;
    t_band             r_out_band, n_out_band;
    logic              r_out_valid, n_out_valid;
    logic [LUX_W-1:0]  r_held,     n_held;
    logic [GAIN_W-1:0] r_gain,     n_gain;
    logic [INTEG_W-1:0] r_integ,   n_integ;

    logic [CH_W:0]     w_sum;
    logic [CMP_W-1:0]  w_lhs;
    logic [COEF_W-1:0] w_coef;
    logic [ACC_W:0]    w_diff;
    logic [DEN_W:0]    w_trial;
    logic [GAIN_W-1:0] w_g;
    logic [INTEG_W-1:0] w_t;
    logic              w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_fresh     = r_fresh;
        n_ch0       = r_ch0;
        n_ch1       = r_ch1;
        n_band      = r_band;
        n_lux       = r_lux;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_den       = r_den;
        n_iter      = r_iter;
        n_out_lux   = r_out_lux;
        n_out_band  = r_out_band;
        n_out_valid = r_out_valid && !i_out_ready;
        n_held      = r_held;
        n_gain      = r_gain;
        n_integ     = r_integ;

        w_sum   = {1'b0, r_ch0} + {1'b0, r_ch1};
        w_lhs   = CMP_W'(r_ch1) * RATIO_DEN;
        w_diff  = {1'b0, r_acc} - {{(ACC_W+1-PROD_W){1'b0}}, r_prod};
        w_trial = {r_rem, r_quo[NUM_W-1]};
        w_g     = (r_gain == '0) ? GAIN_W'(1) : r_gain;
        w_t     = (r_integ == '0) ? INTEG_W'(1) : r_integ;

        case (i_op)
            OP_MUL_A: begin
                case (r_band)
                    BAND_1:  w_coef = C_A1;
                    BAND_2:  w_coef = C_A2;
                    default: w_coef = C_A3;
                endcase
            end
            default: begin
                case (r_band)
                    BAND_1:  w_coef = C_B1;
                    BAND_2:  w_coef = C_B2;
                    default: w_coef = C_B3;
                endcase
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN:  n_gain  = i_cfg_data[GAIN_W-1:0];
                CFG_INTEG: n_integ = i_cfg_data[INTEG_W-1:0];
                default:   n_gain  = r_gain;
            endcase
        end

        case (i_op)
            OP_LOAD: begin
                if (i_in_valid) begin
                    n_fresh = i_fresh;
                    n_ch0   = i_ch_visible_ir;
                    n_ch1   = i_ch_ir;
                end
            end
            OP_CLASS: begin
                n_lux = '0;
                if (!r_fresh) begin
                    n_band = BAND_HELD;
                    n_lux  = r_held;
                end else if (r_ch0 == '0 || r_ch1 == '0) begin
                    n_band = BAND_ZERO;
                end else if (w_lhs < CMP_W'(w_sum) * RATIO_1) begin
                    n_band = BAND_1;
                end else if (w_lhs < CMP_W'(w_sum) * RATIO_2) begin
                    n_band = BAND_2;
                end else if (w_lhs < CMP_W'(w_sum) * RATIO_3) begin
                    n_band = BAND_3;
                end else begin
                    n_band = BAND_HIGH;
                end
            end
            OP_MUL_A: begin
                n_prod = PROD_W'(w_coef) * PROD_W'(r_ch0);
            end
            OP_MUL_B: begin
                n_acc  = ACC_W'(r_prod);
                n_prod = PROD_W'(w_coef) * PROD_W'(r_ch1);
            end
            OP_SUM: begin
                if (r_band == BAND_2) begin
                    // negative difference clamps to zero
                    n_acc = w_diff[ACC_W] ? '0 : w_diff[ACC_W-1:0];
                end else begin
                    n_acc = r_acc + ACC_W'(r_prod);
                end
            end
            OP_DIV_INIT: begin
                // 2*S / 2^F == S / 2^(F-1); shift first, then divide by gain*time
                n_quo  = r_acc[COEF_FRAC_BITS-1 +: NUM_W];
                n_rem  = '0;
                n_den  = DEN_W'(w_g) * DEN_W'(w_t);
                n_iter = ITER_W'(NUM_W - 1);
            end
            OP_DIV_STEP: begin
                if (w_trial >= {1'b0, r_den}) begin
                    n_rem = DEN_W'(w_trial - {1'b0, r_den});
                    n_quo = {r_quo[NUM_W-2:0], 1'b1};
                end else begin
                    n_rem = w_trial[DEN_W-1:0];
                    n_quo = {r_quo[NUM_W-2:0], 1'b0};
                end
                n_iter = r_iter - ITER_W'(1);
            end
            OP_DIV_END: begin
                n_lux = (r_quo > NUM_W'(LUX_MAX)) ? LUX_MAX : r_quo[LUX_W-1:0];
            end
            OP_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_lux   = r_lux;
                    n_out_band  = r_band;
                    if (r_band != BAND_ZERO && r_band != BAND_HELD) begin
                        n_held = r_lux;
                    end
                end
            end
            default: begin
                n_lux = r_lux;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_held      <= '0;
            r_gain      <= GAIN_W'(1);
            r_integ     <= INTEG_W'(2);
        end else begin
            r_out_valid <= n_out_valid;
            r_held      <= n_held;
            r_gain      <= n_gain;
            r_integ     <= n_integ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fresh    <= n_fresh;
        r_ch0      <= n_ch0;
        r_ch1      <= n_ch1;
        r_band     <= n_band;
        r_lux      <= n_lux;
        r_prod     <= n_prod;
        r_acc      <= n_acc;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_den      <= n_den;
        r_iter     <= n_iter;
        r_out_lux  <= n_out_lux;
        r_out_band <= n_out_band;
    end

    assign o_stat.special  = (r_band == BAND_ZERO) || (r_band == BAND_HIGH)
                             || (r_band == BAND_HELD);
    assign o_stat.div_more = (r_iter != '0);
    assign o_stat.out_free = w_out_free;
    assign o_out_valid     = r_out_valid;
    assign o_lux_value     = r_out_lux;
    assign o_band          = r_out_band;

    `LALC_ASSERT_ALWAYS(a_held_max, i_clk, i_rst_n, r_held <= LUX_MAX, "held lux above saturation limit")
    `LALC_ASSERT_IMPLIES(a_zero_lux, i_clk, i_rst_n, r_out_valid && (r_out_band == BAND_ZERO || r_out_band == BAND_HIGH), r_out_lux == '0, "zero band with nonzero lux")
    `LALC_ASSERT_IMPLIES(a_rem_range, i_clk, i_rst_n, i_op == OP_DIV_STEP, r_rem < r_den, "divider remainder out of range")

endmodule

`default_nettype wire

@@ src/ambient_light_lux_calc.sv @@
// A ratio-band word is classified, multiplied by two coefficients, summed
// and divided; a held, zero-channel or ratio-too-high word goes straight to
// emit. The 21-iteration restoring divider is run by the microcode loop; a
// new word is accepted only after the previous result is emitted.
// Reset: synchronous active low; clears the sequencer, output valid and
// held lux, and sets gain to 1 and integration halves to 2.
`default_nettype none

module ambient_light_lux_calc
    import lalc_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire [IN_DATA_W-1:0]   s_axis_tdata,  // ch_visible_ir[15:0], ch_ir[31:16]
    input  wire                   s_axis_tuser,  // fresh
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // lux_value[19:0], zero pad
    output logic [BAND_W-1:0]     m_axis_tuser,  // band
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_W-1:0]       i_cfg_data
);

    t_op              w_op;
    t_stat            w_stat;
    logic [LUX_W-1:0] w_lux;
    t_band            w_band;

    lalc_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (w_stat),
        .o_op       (w_op)
    );

    lalc_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (w_op),
        .i_in_valid      (s_axis_tvalid),
        .i_fresh         (s_axis_tuser),
        .i_ch_visible_ir (s_axis_tdata[CH_W-1:0]),
        .i_ch_ir         (s_axis_tdata[2*CH_W-1:CH_W]),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (m_axis_tready),
        .o_stat          (w_stat),
        .o_out_valid     (m_axis_tvalid),
        .o_lux_value     (w_lux),
        .o_band          (w_band)
    );

    assign s_axis_tready = (w_op == OP_LOAD);
    assign m_axis_tdata  = {{(OUT_DATA_W-LUX_W){1'b0}}, w_lux};
    assign m_axis_tuser  = w_band;

endmodule

`default_nettype wire
